### hw/rtl/dram_command_timing_checker_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the DRAM command timing checker.
// Every macro samples on clk and is disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef DRAM_COMMAND_TIMING_CHECKER_ASSERT_SVH
`define DRAM_COMMAND_TIMING_CHECKER_ASSERT_SVH

// Property that must hold at every sampled edge.
`define DCTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that, once seen, must be followed by a consequence in the next cycle.
`define DCTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/dctc_pkg.sv
// ----------------------------------------------------------------------------
// dctc_pkg
// Shared types, codes and constants of the DRAM command timing checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dctc_pkg;

  // Default sizes handed to the top level parameters.
  localparam int DEF_BANKS     = 8;
  localparam int DEF_TIME_BITS = 48;

  // Command occupancy on the bus, added to activate and precharge completion.
  localparam int CMD_CYCLES = 1;

  // Fixed field widths.
  localparam int NOW_W     = 48;
  localparam int BANK_W    = 4;
  localparam int ROW_W     = 17;
  localparam int KIND_W    = 3;
  localparam int REG_W     = 8;
  localparam int CFG_IDX_W = 3;

  // Request kinds.
  localparam logic [KIND_W-1:0] REQ_ROW  = 3'd0;
  localparam logic [KIND_W-1:0] REQ_ACT  = 3'd1;
  localparam logic [KIND_W-1:0] REQ_PRE  = 3'd2;
  localparam logic [KIND_W-1:0] REQ_WR   = 3'd3;
  localparam logic [KIND_W-1:0] REQ_RD   = 3'd4;
  localparam logic [KIND_W-1:0] REQ_DONE = 3'd5;

  // Bank code that addresses every bank at once.
  localparam logic [BANK_W-1:0] BANK_ALL = 4'b1111;

  // Row code for a closed bank.
  localparam logic [ROW_W-1:0] ROW_CLOSED = 17'h1FFFF;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BURST     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_LAT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_LAT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FAW       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RAS       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RRD       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RP        = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_WR_REC    = 3'd7;

  // Configuration reset values.
  localparam logic [REG_W-1:0] RST_BURST     = 8'd4;
  localparam logic [REG_W-1:0] RST_READ_LAT  = 8'd11;
  localparam logic [REG_W-1:0] RST_WRITE_LAT = 8'd8;
  localparam logic [REG_W-1:0] RST_FAW       = 8'd24;
  localparam logic [REG_W-1:0] RST_RAS       = 8'd28;
  localparam logic [REG_W-1:0] RST_RRD       = 8'd5;
  localparam logic [REG_W-1:0] RST_RP        = 8'd11;
  localparam logic [REG_W-1:0] RST_WR_REC    = 8'd12;

  // Timing configuration as seen by the engine.
  typedef struct packed {
    logic [REG_W-1:0] burst_cycles;
    logic [REG_W-1:0] read_latency;
    logic [REG_W-1:0] write_latency;
    logic [REG_W-1:0] four_act_window;
    logic [REG_W-1:0] act_to_precharge;
    logic [REG_W-1:0] act_to_act;
    logic [REG_W-1:0] precharge_time;
    logic [REG_W-1:0] write_recovery;
  } cfg_t;

  // One response.
  typedef struct packed {
    logic             error;
    logic             done_res;
    logic [ROW_W-1:0] open_row;
    logic             available;
  } result_t;

endpackage

### hw/rtl/dctc_cfg_regs.sv
// ----------------------------------------------------------------------------
// dctc_cfg_regs
// Timing configuration registers, written by index through a plain port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dctc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [dctc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dctc_pkg::REG_W-1:0]     cfg_data,
  output dctc_pkg::cfg_t                 cfg
);
  import dctc_pkg::*;

  // Register file with per-register reset values.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.burst_cycles     <= RST_BURST;
      cfg.read_latency     <= RST_READ_LAT;
      cfg.write_latency    <= RST_WRITE_LAT;
      cfg.four_act_window  <= RST_FAW;
      cfg.act_to_precharge <= RST_RAS;
      cfg.act_to_act       <= RST_RRD;
      cfg.precharge_time   <= RST_RP;
      cfg.write_recovery   <= RST_WR_REC;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BURST:     cfg.burst_cycles     <= cfg_data;
        CFG_READ_LAT:  cfg.read_latency     <= cfg_data;
        CFG_WRITE_LAT: cfg.write_latency    <= cfg_data;
        CFG_FAW:       cfg.four_act_window  <= cfg_data;
        CFG_RAS:       cfg.act_to_precharge <= cfg_data;
        CFG_RRD:       cfg.act_to_act       <= cfg_data;
        CFG_RP:        cfg.precharge_time   <= cfg_data;
        CFG_WR_REC:    cfg.write_recovery   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### hw/rtl/dctc_engine.sv
// ----------------------------------------------------------------------------
// dctc_engine
// Timing state and the single-pass decision logic for one request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dram_command_timing_checker_assert.svh"

module dctc_engine #(
  parameter int BANKS     = dctc_pkg::DEF_BANKS,
  parameter int TIME_BITS = dctc_pkg::DEF_TIME_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_fire,
  input  logic [dctc_pkg::KIND_W-1:0]        req_type,
  input  logic                               issue,
  input  logic [TIME_BITS-1:0]               now,
  input  logic signed [dctc_pkg::BANK_W-1:0] bank,
  input  logic signed [dctc_pkg::ROW_W-1:0]  row,
  input  dctc_pkg::cfg_t                     cfg,
  output dctc_pkg::result_t                  result
);
  import dctc_pkg::*;

  localparam int IDX_W = (BANKS > 1) ? $clog2(BANKS) : 1;
  localparam int OFS_W = 10;

  // Saturating add of a time and a small offset.
  function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                   input logic [TIME_BITS-1:0] b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
  endfunction

  // Timing state.
  logic [TIME_BITS-1:0] current_time;
  logic [TIME_BITS-1:0] done_time;
  logic [TIME_BITS-1:0] activate_ready;
  logic [TIME_BITS-1:0] precharge_ready;
  logic [TIME_BITS-1:0] write_ready;
  logic [TIME_BITS-1:0] read_ready;
  logic [TIME_BITS-1:0] act_hist [4];
  logic [ROW_W-1:0]     bank_open_row [BANKS];

  // Decode and decision signals.
  logic                 is_row, is_cmd, is_act, is_pre, is_done;
  logic                 bank_ok, bank_all, cmd_bank_bad;
  logic [IDX_W-1:0]     bank_idx;
  logic [TIME_BITS-1:0] ready_sel;
  logic                 avail_raw;
  logic                 err;
  logic                 do_issue;
  logic                 cur_update;
  logic [OFS_W-1:0]     done_ofs;
  logic [TIME_BITS-1:0] done_new;
  logic [TIME_BITS-1:0] rrd_bound;
  logic [TIME_BITS-1:0] faw_bound;
  logic [TIME_BITS-1:0] ras_bound;
  logic [TIME_BITS-1:0] act_ready_new;

  // Request decode and bank range check.
  always_comb begin
    is_row   = (req_type == REQ_ROW);
    is_act   = (req_type == REQ_ACT);
    is_pre   = (req_type == REQ_PRE);
    is_done  = (req_type == REQ_DONE);
    is_cmd   = req_type inside {[REQ_ACT:REQ_RD]};
    bank_all = (bank == BANK_ALL);
    bank_ok  = !bank[BANK_W-1] &&
               (5'({1'b0, bank[BANK_W-2:0]}) < 5'(BANKS));
    bank_idx = IDX_W'(bank[BANK_W-2:0]);
    cmd_bank_bad = (is_act || is_pre) && !(bank_ok || bank_all);
  end

  // Ready time of the requested command and the completion offset it adds.
  always_comb begin
    case (req_type)
      REQ_ACT: begin
        ready_sel = activate_ready;
        done_ofs  = OFS_W'(cfg.act_to_precharge) + OFS_W'(CMD_CYCLES);
      end
      REQ_PRE: begin
        ready_sel = precharge_ready;
        done_ofs  = OFS_W'(cfg.precharge_time) + OFS_W'(CMD_CYCLES);
      end
      REQ_WR: begin
        ready_sel = write_ready;
        done_ofs  = OFS_W'(cfg.write_latency) + OFS_W'(cfg.burst_cycles) +
                    OFS_W'(cfg.write_recovery);
      end
      REQ_RD: begin
        ready_sel = read_ready;
        done_ofs  = OFS_W'(cfg.read_latency) + OFS_W'(cfg.burst_cycles);
      end
      default: begin
        ready_sel = read_ready;
        done_ofs  = '0;
      end
    endcase
  end

  // New time bounds. The window uses the oldest activation after this one is
  // recorded, which is the second entry of the current history.
  always_comb begin
    done_new  = sat_add(now, TIME_BITS'(done_ofs));
    rrd_bound = sat_add(now, TIME_BITS'(cfg.act_to_act));
    ras_bound = sat_add(now, TIME_BITS'(cfg.act_to_precharge));
    faw_bound = sat_add(act_hist[1], TIME_BITS'(cfg.four_act_window));
    act_ready_new = done_new;
    if (rrd_bound > act_ready_new) begin
      act_ready_new = rrd_bound;
    end
    if (faw_bound > act_ready_new) begin
      act_ready_new = faw_bound;
    end
  end

  // Result and the update decisions.
  always_comb begin
    avail_raw  = (now >= ready_sel);
    err        = (is_row && !bank_ok) ||
                 (is_cmd && (cmd_bank_bad || (issue && !avail_raw))) ||
                 !(is_row || is_cmd || is_done);
    do_issue   = is_cmd && issue && !err;
    cur_update = (is_row && bank_ok) || (is_cmd && !err) ||
                 (is_done && (now >= current_time));

    result.available = (is_row && bank_ok) || (is_cmd && !cmd_bank_bad && avail_raw);
    result.open_row  = (is_row && bank_ok) ? bank_open_row[bank_idx] : '0;
    result.done_res  = is_done && (now >= current_time) && (done_time <= now);
    result.error     = err;
  end

  // Time state.
  always_ff @(posedge clk) begin
    if (rst) begin
      current_time    <= '0;
      done_time       <= '0;
      activate_ready  <= '0;
      precharge_ready <= '0;
      write_ready     <= '0;
      read_ready      <= '0;
      for (int i = 0; i < 4; i++) begin
        act_hist[i] <= '0;
      end
    end else if (in_fire) begin
      if (cur_update) begin
        current_time <= now;
      end
      if (do_issue) begin
        done_time   <= done_new;
        write_ready <= done_new;
        read_ready  <= done_new;
        // An activate also applies its own activate and precharge bounds.
        if (is_act) begin
          activate_ready  <= act_ready_new;
          precharge_ready <= ras_bound;
          act_hist[0]     <= act_hist[1];
          act_hist[1]     <= act_hist[2];
          act_hist[2]     <= act_hist[3];
          act_hist[3]     <= now;
        end else begin
          activate_ready  <= done_new;
          precharge_ready <= done_new;
        end
      end
    end
  end

  // Open row of every bank; all banks are closed after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < BANKS; b++) begin
        bank_open_row[b] <= ROW_CLOSED;
      end
    end else if (in_fire && do_issue && (is_act || is_pre)) begin
      if (bank_all) begin
        for (int b = 0; b < BANKS; b++) begin
          bank_open_row[b] <= row;
        end
      end else begin
        bank_open_row[bank_idx] <= row;
      end
    end
  end

  // An issued command never completes before it was issued.
  `DCTC_ASSERT_NEXT(a_done_not_before_issue, in_fire && do_issue, done_time >= $past(now), "completion time earlier than issue time")
  // A rejected request leaves the time state untouched.
  `DCTC_ASSERT_NEXT(a_error_keeps_state, in_fire && err, $stable(current_time) && $stable(done_time), "rejected request changed time state")
  // An activate never allows the next activate before its own completion.
  `DCTC_ASSERT_NEXT(a_act_ready_covers_done, in_fire && do_issue && is_act, activate_ready >= done_time, "activate ready time below completion time")

endmodule

### hw/rtl/dram_command_timing_checker.sv
// ----------------------------------------------------------------------------
// dram_command_timing_checker
// Top level: request register, timing engine and response register.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter on the s_ stream: s_tuser holds the request kind and the
// issue flag, s_tdata the current time, the bank and the row. Responses leave
// on the m_ stream, one for every request, in request order.
// The cfg_ port writes the eight timing registers; write it only while no
// request is in flight.
// A taken request waits in the input register, where the engine decides it;
// when the response register is free or drains, the decision updates the
// timing state and loads the response register, which shows the response.
// One request is accepted every cycle unless the receiver stalls; each takes
// four saturating adds and a few compares against the stored ready times.
// When the receiver stalls, the response is held and the input register
// absorbs one more request before s_tready falls.
// Reset (rst, synchronous) empties both registers, restores the default
// timing values, clears all ready and history times and closes every bank.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dram_command_timing_checker_assert.svh"

module dram_command_timing_checker #(
  parameter int BANKS     = dctc_pkg::DEF_BANKS,
  parameter int TIME_BITS = dctc_pkg::DEF_TIME_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  // Request stream.
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [71:0]                    s_tdata,  // now[47:0], bank[51:48], row[68:52]
  input  logic [3:0]                     s_tuser,  // req_type[2:0], issue[3]
  // Response stream.
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [23:0]                    m_tdata,  // available[0], open_row[17:1],
                                                   // done_res[18], error[19]
  // Configuration writes.
  input  logic                           cfg_we,
  input  logic [dctc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dctc_pkg::REG_W-1:0]     cfg_data
);
  import dctc_pkg::*;

  // Input register.
  logic                     in_valid;
  logic [KIND_W-1:0]        in_req_type;
  logic                     in_issue;
  logic [NOW_W-1:0]         in_now;
  logic signed [BANK_W-1:0] in_bank;
  logic signed [ROW_W-1:0]  in_row;

  // Response register.
  logic    out_valid;
  result_t out_result;

  logic    advance;
  cfg_t    cfg;
  result_t result;

  // The input register moves on when the response register is free or drains.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // Request capture.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_req_type <= s_tuser[2:0];
      in_issue    <= s_tuser[3];
      in_now      <= s_tdata[47:0];
      in_bank     <= s_tdata[51:48];
      in_row      <= s_tdata[68:52];
    end
  end

  dctc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dctc_engine #(
    .BANKS     (BANKS),
    .TIME_BITS (TIME_BITS)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (advance),
    .req_type (in_req_type),
    .issue    (in_issue),
    .now      (TIME_BITS'(in_now)),
    .bank     (in_bank),
    .row      (in_row),
    .cfg      (cfg),
    .result   (result)
  );

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0, out_result};

  // With both registers full and the receiver stalled, no request is taken.
  `DCTC_ASSERT(a_full_blocks_input, (in_valid && out_valid && !m_tready) |-> !s_tready, "request taken while both stages are full")
  // A request in the input register reaches the response register at once
  // whenever the response side is free.
  `DCTC_ASSERT_NEXT(a_free_output_loads, in_valid && !out_valid, out_valid, "pending request did not reach the response register")

endmodule
